@@ hdl/emc_pkg.sv @@
`timescale 1ns / 1ps
package emc_pkg;
    localparam int SUBSET_COUNT = 8;
    localparam int SUB_W = 3;
    localparam int MASS_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W = 38;
    localparam int NUM_W = SUM_W + 15;
    localparam int DIV_CNT_W = 6;

    typedef logic [SUB_W-1:0] subset_t;
    typedef logic [MASS_W-1:0] mass_t;

    typedef struct packed {
        logic [SUB_W-1:0]  subset;
        logic [MASS_W-1:0] mass_value;
        logic              first_source;
        logic              last_element;
    } in_req_t;

    typedef struct packed {
        logic [SUB_W-1:0]  out_subset;
        logic [MASS_W-1:0] out_mass;
        logic [MASS_W-1:0] out_belief;
        logic [MASS_W-1:0] out_plausibility;
        logic              total_conflict;
        logic              last_result;
    } out_req_t;

    typedef enum logic [3:0] {
        ST_LOAD, ST_CLEAR, ST_MAC, ST_KSUM, ST_DIV_START, ST_DIV_RUN,
        ST_DIV_STORE, ST_EMIT, ST_EMIT_WAIT
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic store_elem;
        logic copy_first;
        logic clear_sums;
        logic mac;
        logic ksum;
        logic div_start;
        logic div_step;
        logic div_store;
        logic zero_conflict;
        logic emit;
        logic clear_incoming;
        logic [SUB_W-1:0] idx_a;
        logic [SUB_W-1:0] idx_b;
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic is_first;
        logic k_zero;
        logic out_busy;
    } stat_t;
endpackage

@@ hdl/emc_if.sv @@
`timescale 1ns / 1ps
interface emc_in_if;
    logic valid;
    logic ready;
    emc_pkg::in_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface emc_out_if;
    logic valid;
    logic ready;
    emc_pkg::out_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/evidence_mass_combiner_top.sv @@
`timescale 1ns / 1ps
// After the last element, a first source goes straight to emitting results;
// when combining, sums are cleared, the MAC sweep runs, K is summed, then each
// non-empty subset is divided (skipped on total conflict). Throughput: one element
// per cycle while loading; 8 results, one per cycle unless the output stalls.
// The divider (one quotient bit a cycle) and the shared multiplier set the
// combining time. Reset (rst_n, async low) clears all masses, flags and out_valid.
module evidence_mass_combiner_top (
    input logic clk,
    input logic rst_n,
    emc_in_if.sink    in_ch,
    emc_out_if.source out_ch
);
    import emc_pkg::*;

    cmd_t cmd;
    stat_t stat;

    emc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.data.last_element),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    emc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_ch.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data)
    );
endmodule

@@ hdl/emc_ctrl.sv @@
`timescale 1ns / 1ps
module emc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    input  emc_pkg::stat_t stat,
    output emc_pkg::cmd_t  cmd
);
    import emc_pkg::*;

    state_t state_reg, state_next;
    logic [2*SUB_W-1:0] cnt_reg, cnt_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic first_reg, first_next;

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        dcnt_next = dcnt_reg;
        first_next = first_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    first_next = stat.is_first;
                    cnt_next = '0;
                    state_next = stat.is_first ? ST_EMIT : ST_CLEAR;
                end
            end
            ST_CLEAR:
                state_next = ST_MAC;
            ST_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    cnt_next = 6'd1;
                    state_next = ST_KSUM;
                end
            end
            ST_KSUM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[SUB_W-1:0] == '1)
                begin
                    cnt_next = 6'd1;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                if (stat.k_zero)
                begin
                    cnt_next = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    dcnt_next = '0;
                    state_next = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN:
            begin
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_CNT_W'(16))
                    state_next = ST_DIV_STORE;
            end
            ST_DIV_STORE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[SUB_W-1:0] == '1)
                begin
                    cnt_next = '0;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_DIV_START;
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[SUB_W-1:0] == '1)
                        state_next = ST_EMIT_WAIT;
                end
            end
            ST_EMIT_WAIT:
                if (!stat.out_busy)
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Command decode
    always_comb
    begin
        cmd = '0;
        cmd.idx_a = cnt_reg[2*SUB_W-1:SUB_W];
        cmd.idx_b = cnt_reg[SUB_W-1:0];
        in_ready = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.store_elem = in_valid;
                cmd.copy_first = in_valid && in_last && stat.is_first;
            end
            ST_CLEAR:     cmd.clear_sums = 1'b1;
            ST_MAC:       cmd.mac = 1'b1;
            ST_KSUM:      cmd.ksum = 1'b1;
            ST_DIV_START:
            begin
                cmd.div_start = !stat.k_zero;
                cmd.zero_conflict = stat.k_zero;
            end
            ST_DIV_RUN:   cmd.div_step = (dcnt_reg != '0);
            ST_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                cmd.clear_incoming = (cnt_reg[SUB_W-1:0] == '1);
            end
            ST_EMIT:
            begin
                cmd.emit = !stat.out_busy;
                cmd.clear_incoming = first_reg || stat.k_zero;
            end
            ST_EMIT_WAIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0;
            dcnt_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            dcnt_reg <= dcnt_next;
            first_reg <= first_next;
        end
    end

    a_ready_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_LOAD) else $error("ready outside load");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_STORE |-> $past(state_reg) == ST_DIV_RUN)
        else $error("divider store early");
    a_mac_to_ksum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && cnt_reg == '1) |=> state_reg == ST_KSUM)
        else $error("mac sweep end");
endmodule

@@ hdl/emc_dp.sv @@
`timescale 1ns / 1ps
module emc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  emc_pkg::in_req_t  in_data,
    input  emc_pkg::cmd_t     cmd,
    output emc_pkg::stat_t    stat,
    output logic              out_valid,
    input  logic              out_ready,
    output emc_pkg::out_req_t out_data
);
    import emc_pkg::*;

    mass_t comb_reg [SUBSET_COUNT];
    mass_t inc_reg [SUBSET_COUNT];
    logic [SUM_W-1:0] isum_reg [SUBSET_COUNT];
    logic first_reg;
    logic [SUM_W-1:0] k_reg;
    logic conflict_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUB_W-1:0] pidx_reg;
    logic prod_vld_reg;
    logic [NUM_W-1:0] num_reg;
    logic [SUM_W:0] rem_reg;
    logic [MASS_W:0] quo_reg;
    logic out_valid_reg;
    out_req_t out_reg;
    logic [SUM_W:0] rem_sh;
    logic [MASS_W+2:0] bel_sum, pl_sum;

    assign stat.is_first = first_reg || in_data.first_source;
    assign stat.k_zero = (k_reg == '0);
    assign stat.out_busy = out_valid_reg && !out_ready;

    // Restoring divider: one quotient bit per step over the low 16 bits of S*2^15
    assign rem_sh = {rem_reg[SUM_W-1:0], num_reg[NUM_W-1]};

    // Belief / plausibility for the subset being emitted
    always_comb
    begin
        bel_sum = '0;
        pl_sum = '0;
        for (int b = 1; b < SUBSET_COUNT; b++)
        begin
            if ((SUB_W'(b) & cmd.idx_b) == SUB_W'(b))
                bel_sum = bel_sum + (MASS_W+3)'(comb_reg[b]);
            if ((SUB_W'(b) & cmd.idx_b) != '0)
                pl_sum = pl_sum + (MASS_W+3)'(comb_reg[b]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SUBSET_COUNT; i++)
            begin
                comb_reg[i] <= '0;
                inc_reg[i] <= '0;
                isum_reg[i] <= '0;
            end
            first_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            prod_reg <= '0;
            pidx_reg <= '0;
            num_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            conflict_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            if (cmd.store_elem)
            begin
                inc_reg[in_data.subset] <= in_data.mass_value;
                first_reg <= !in_data.last_element &&
                             (first_reg || in_data.first_source);
            end
            if (cmd.copy_first)
            begin
                for (int i = 0; i < SUBSET_COUNT; i++)
                    comb_reg[i] <= (SUB_W'(i) == in_data.subset) ?
                                   in_data.mass_value : inc_reg[i];
                conflict_reg <= 1'b0;
            end
            if (cmd.clear_sums)
                k_reg <= '0;
            // Multiply stage then accumulate
            prod_vld_reg <= cmd.mac;
            prod_reg <= comb_reg[cmd.idx_a] * inc_reg[cmd.idx_b];
            pidx_reg <= cmd.idx_a & cmd.idx_b;
            if (prod_vld_reg)
                isum_reg[pidx_reg] <= isum_reg[pidx_reg] + SUM_W'(prod_reg);
            if (cmd.clear_sums)
                for (int i = 0; i < SUBSET_COUNT; i++)
                    isum_reg[i] <= '0;
            if (cmd.ksum)
                k_reg <= k_reg + isum_reg[cmd.idx_b];
            if (cmd.zero_conflict)
            begin
                for (int i = 0; i < SUBSET_COUNT; i++)
                    comb_reg[i] <= '0;
                conflict_reg <= 1'b1;
            end
            // S <= K, so S*2^15 >> 16 = S >> 1 is already below K: preload it
            if (cmd.div_start)
            begin
                num_reg <= {isum_reg[cmd.idx_b][0], {(NUM_W-1){1'b0}}};
                rem_reg <= {2'b00, isum_reg[cmd.idx_b][SUM_W-1:1]};
                quo_reg <= '0;
                conflict_reg <= 1'b0;
            end
            if (cmd.div_step)
            begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, k_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, k_reg};
                    quo_reg <= {quo_reg[MASS_W-1:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[MASS_W-1:0], 1'b0};
                end
            end
            if (cmd.div_store)
            begin
                comb_reg[cmd.idx_b] <= quo_reg[MASS_W-1:0];
                comb_reg[0] <= '0;
            end
            if (cmd.clear_incoming)
                for (int i = 0; i < SUBSET_COUNT; i++)
                    inc_reg[i] <= '0;
            // Output register
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.out_subset <= cmd.idx_b;
            out_reg.out_mass <= comb_reg[cmd.idx_b];
            out_reg.out_belief <= (bel_sum > (MASS_W+3)'(16'hFFFF)) ?
                                  16'hFFFF : bel_sum[MASS_W-1:0];
            out_reg.out_plausibility <= (pl_sum > (MASS_W+3)'(16'hFFFF)) ?
                                        16'hFFFF : pl_sum[MASS_W-1:0];
            out_reg.total_conflict <= conflict_reg;
            out_reg.last_result <= (cmd.idx_b == '1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_no_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !out_ready)) else $error("overwrite");
    a_mass_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_store |-> quo_reg <= (MASS_W+1)'(32768)) else $error("mass range");
endmodule
